[rtl/mfs_pkg.sv]
// Shared constants, codes and control types of the maximum-frequency stack.
package mfs_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int IDX_W       = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int TAG_W       = CNT_W;
	localparam int VAL_W       = 32;

	typedef enum logic [1:0] {
		STATUS_DONE  = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic [TAG_W-1:0]        tag;
	} slot_t;

	typedef struct packed {
		logic    load;
		logic    scan;
		logic    shift;
		logic    shift_init;
		logic    push_wr;
		logic    pop_commit;
		logic    res_load;
		logic    res_pop;
		status_t res_status;
		logic    out_load;
	} cmd_t;

	typedef struct packed {
		logic fill_zero;
		logic fill_full;
		logic scan_done;
	} dp_status_t;

endpackage

[rtl/mfs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module mfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/mfs_datapath.sv]
// Datapath: slot memory, scan counters, match count, maximum select and result registers.
module mfs_datapath import mfs_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cmd_t                    cmd,
	input  logic signed [VAL_W-1:0] push_value,
	output dp_status_t              st,
	output logic signed [VAL_W-1:0] popped_value,
	output logic [1:0]              status
);

	logic [CNT_W-1:0]        fill_q;
	logic [CNT_W-1:0]        rd_idx_q;
	logic                    rd_vld_s1;
	logic [IDX_W-1:0]        rd_idx_s1;
	logic signed [VAL_W-1:0] op_value_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [TAG_W-1:0]        best_tag_q;
	logic [IDX_W-1:0]        best_idx_q;
	logic signed [VAL_W-1:0] best_val_q;
	logic signed [VAL_W-1:0] res_value_q;
	status_t                 res_status_q;
	logic signed [VAL_W-1:0] popped_value_q;
	status_t                 status_q;

	logic             issue;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	slot_t            mem_wdata;
	slot_t            rd_data;

	assign issue = (cmd.scan || cmd.shift) && (rd_idx_q < fill_q);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = rd_idx_s1 - IDX_W'(1);
		mem_wdata = rd_data;
		if (cmd.push_wr) begin
			mem_we          = 1'b1;
			mem_waddr       = fill_q[IDX_W-1:0];
			mem_wdata.value = op_value_q;
			mem_wdata.tag   = TAG_W'(cnt_q) + TAG_W'(1);
		end else if (cmd.shift && rd_vld_s1) begin
			mem_we = 1'b1;
		end
	end

	mfs_ram #(
		.WIDTH($bits(slot_t)),
		.DEPTH(STACK_DEPTH)
	) u_slots (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (issue),
		.raddr(rd_idx_q[IDX_W-1:0]),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (cmd.load) begin
				rd_idx_q <= '0;
			end else if (cmd.shift_init) begin
				rd_idx_q <= CNT_W'(best_idx_q) + CNT_W'(1);
			end else if (issue) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
			if (cmd.push_wr) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (cmd.pop_commit) begin
				fill_q <= fill_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_idx_q[IDX_W-1:0];
		if (cmd.load) begin
			op_value_q <= push_value;
			cnt_q      <= '0;
			best_tag_q <= '0;
			best_idx_q <= '0;
		end else if (cmd.scan && rd_vld_s1) begin
			if (rd_data.value == op_value_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (rd_data.tag >= best_tag_q) begin
				best_tag_q <= rd_data.tag;
				best_idx_q <= rd_idx_s1;
				best_val_q <= rd_data.value;
			end
		end
		if (cmd.res_load) begin
			res_value_q  <= cmd.res_pop ? best_val_q : '0;
			res_status_q <= cmd.res_status;
		end
		if (cmd.out_load) begin
			popped_value_q <= res_value_q;
			status_q       <= res_status_q;
		end
	end

	assign st.fill_zero = (fill_q == '0);
	assign st.fill_full = (fill_q == CNT_W'(STACK_DEPTH));
	assign st.scan_done = !issue && !rd_vld_s1;

	assign popped_value = popped_value_q;
	assign status       = status_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(STACK_DEPTH))
		else $error("fill level beyond stack depth");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_wr |-> fill_q < CNT_W'(STACK_DEPTH))
		else $error("slot write on full stack");

	a_pop_live: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_commit |-> fill_q != '0)
		else $error("pop commit on empty stack");

	a_push_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_wr |=> fill_q == $past(fill_q) + CNT_W'(1))
		else $error("push did not advance fill level by one");

endmodule

[rtl/mfs_ctrl.sv]
// Controller: sequences scan, shift, slot write and result hand-off for each transaction.
module mfs_ctrl import mfs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       action,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t st,
	output cmd_t       cmd
);

	typedef enum logic [5:0] {
		S_IDLE      = 6'b000001,
		S_PUSH_SCAN = 6'b000010,
		S_PUSH_WR   = 6'b000100,
		S_POP_SCAN  = 6'b001000,
		S_POP_SHIFT = 6'b010000,
		S_RESP      = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.res_status = STATUS_DONE;
		in_ready       = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (!action) begin
						if (st.fill_full) begin
							cmd.res_load   = 1'b1;
							cmd.res_status = STATUS_FULL;
							state_d        = S_RESP;
						end else if (st.fill_zero) begin
							state_d = S_PUSH_WR;
						end else begin
							state_d = S_PUSH_SCAN;
						end
					end else begin
						if (st.fill_zero) begin
							cmd.res_load   = 1'b1;
							cmd.res_status = STATUS_EMPTY;
							state_d        = S_RESP;
						end else begin
							state_d = S_POP_SCAN;
						end
					end
				end
			end
			S_PUSH_SCAN: begin
				cmd.scan = 1'b1;
				if (st.scan_done) begin
					state_d = S_PUSH_WR;
				end
			end
			S_PUSH_WR: begin
				cmd.push_wr  = 1'b1;
				cmd.res_load = 1'b1;
				state_d      = S_RESP;
			end
			S_POP_SCAN: begin
				cmd.scan = 1'b1;
				if (st.scan_done) begin
					cmd.shift_init = 1'b1;
					state_d        = S_POP_SHIFT;
				end
			end
			S_POP_SHIFT: begin
				cmd.shift = 1'b1;
				if (st.scan_done) begin
					cmd.pop_commit = 1'b1;
					cmd.res_load   = 1'b1;
					cmd.res_pop    = 1'b1;
					state_d        = S_RESP;
				end
			end
			S_RESP: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> out_free && state_q == S_RESP)
		else $error("result loaded over a pending transaction");

	a_shift_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_POP_SHIFT |-> $past(state_q) == S_POP_SCAN || $past(state_q) == S_POP_SHIFT)
		else $error("shift entered without a maximum scan");

	a_out_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q)
		else $error("result register loaded without valid");

endmodule

[rtl/max_frequency_stack_unit.sv]
// Top level of the maximum-frequency stack: controller and datapath.
//
// Input channel (in_valid/in_ready, action, push_value): action 0 pushes
// push_value, tagged with its occurrence count among live entries; action 1
// pops the entry with the greatest tag, the most recently pushed on a tie.
// Output channel (out_valid/out_ready, popped_value, status) returns one
// transaction per input: status 0 done, 1 pop on empty stack, 2 push on full
// stack; popped_value is zero except on a successful pop.
// With N live entries and the popped entry at slot b, the next input is
// accepted from the edge at which the result can first be taken. Each
// successful push or pop costs one slot memory read per live entry (match
// count or maximum scan), and a pop one more read per entry above b to close
// the gap, all through the single read port of the memory.
// Reset empties the stack; slot contents are left as they are.
// A finished result waits in the output register while the next transaction
// is accepted; if the receiver stalls, the following result holds in the
// datapath until the output register frees.
module max_frequency_stack_unit import mfs_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    action,
	input  logic signed [VAL_W-1:0] push_value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [VAL_W-1:0] popped_value,
	output logic [1:0]              status
);

	cmd_t       cmd;
	dp_status_t st;

	mfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.action   (action),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.st       (st),
		.cmd      (cmd)
	);

	mfs_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.push_value  (push_value),
		.st          (st),
		.popped_value(popped_value),
		.status      (status)
	);

endmodule
